FILE: design/lx200_pkg.sv
// Package for the LX200 command parser: result and command descriptor types.
// No dependencies; used by every module of the block.
`default_nettype none
package lx200_pkg;
	localparam int unsigned CmdMax = 19;

	typedef logic [3:0] status_t;
	localparam status_t StFail   = 4'd0;
	localparam status_t StDone   = 4'd1;
	localparam status_t StRaSet  = 4'd2;
	localparam status_t StDecSet = 4'd3;
	localparam status_t StMoveE  = 4'd4;
	localparam status_t StMoveW  = 4'd5;
	localparam status_t StMoveS  = 4'd6;
	localparam status_t StMoveN  = 4'd7;
	localparam status_t StStopE  = 4'd8;
	localparam status_t StStopW  = 4'd9;
	localparam status_t StStopS  = 4'd10;
	localparam status_t StStopN  = 4'd11;

	typedef enum logic [2:0] {
		RepNone, RepOne, RepZero, RepGr, RepGd
	} rep_kind_t;

	// Decoded command handed from front to back.
	typedef struct packed {
		rep_kind_t    kind;
		status_t      status;
		logic [31:0]  target;
		logic [20:0]  ra;
		logic [19:0]  dec;
	} cmd_t;

	typedef enum logic [1:0] {BkIdle, BkConv, BkEmit} bk_state_t;
endpackage
`default_nettype wire

FILE: design/lx200_front.sv
// Front part: byte capture, header search and command classification.
// Depends on lx200_pkg.
`default_nettype none
module lx200_front #(
	parameter int unsigned MessageLength = 64,
	parameter int unsigned CommandLength = 19
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic [7:0]       rx_byte,
	input  wire logic             end_of_message,
	input  wire logic [20:0]      ra_position,
	input  wire logic [19:0]      dec_position,
	output lx200_pkg::cmd_t       cmd_out,
	output logic                  cmd_valid
);
	import lx200_pkg::*;

	localparam int unsigned IdxW = $clog2(MessageLength + 1);

	logic [7:0]      buf_q [CmdMax];
	logic [4:0]      cnt_q;
	logic            hdr_q;
	logic [IdxW-1:0] idx_q;

	logic [7:0]  nb [CmdMax];
	logic        hdr_n;
	logic        in_win;
	cmd_t        c;

	assign in_win = idx_q < IdxW'(MessageLength);
	assign hdr_n = hdr_q || (in_win && (32'(idx_q) + 32'd5 <= 32'(MessageLength))
		&& rx_byte == 8'h3A);

	always_comb begin
		for (int i = 0; i < CmdMax; i++) begin
			nb[i] = buf_q[i];
			if (i < CommandLength && in_win && hdr_n && cnt_q == 5'(i))
				nb[i] = rx_byte;
			if (i >= CommandLength)
				nb[i] = 8'd0;
		end
	end

	function automatic logic [31:0] dg(input logic [7:0] b);
		return {24'd0, b} - 32'd48;
	endfunction

	logic [31:0] qr, sr, d1, d2, dsel;
	logic [7:0]  sgn;
	always_comb begin
		qr = dg(nb[7]) * 32'd540000 + dg(nb[8]) * 32'd54000 + dg(nb[10]) * 32'd9000
			+ dg(nb[11]) * 32'd900 + dg(nb[13]) * 32'd150 + dg(nb[14]) * 32'd15;
		sr = dg(nb[3]) * 32'd540000 + dg(nb[4]) * 32'd54000 + dg(nb[6]) * 32'd9000
			+ dg(nb[7]) * 32'd900 + dg(nb[9]) * 32'd150 + dg(nb[10]) * 32'd15;
		d1 = dg(nb[5]) * 32'd36000 + dg(nb[6]) * 32'd3600 + dg(nb[8]) * 32'd600
			+ dg(nb[9]) * 32'd60 + dg(nb[11]) * 32'd10 + dg(nb[12]);
		d2 = dg(nb[4]) * 32'd36000 + dg(nb[5]) * 32'd3600 + dg(nb[7]) * 32'd600
			+ dg(nb[8]) * 32'd60 + dg(nb[10]) * 32'd10 + dg(nb[11]);
		if (nb[3] == 8'h20) begin
			dsel = d1; sgn = nb[4];
		end else begin
			dsel = d2; sgn = nb[3];
		end
		if (sgn == 8'h2B) dsel = 32'd324000 + dsel;
		else if (sgn == 8'h2D) dsel = 32'd324000 - dsel;
	end

	always_comb begin
		c = '0;
		c.kind = RepNone;
		c.status = StFail;
		c.ra = ra_position;
		c.dec = dec_position;
		if (hdr_n) begin
			if (nb[1] == "G") begin
				c.status = StDone;
				if (nb[2] == "R") c.kind = RepGr;
				else if (nb[2] == "D") c.kind = RepGd;
			end else if (nb[1] == "Q" && nb[5] == "r") begin
				c.status = StRaSet; c.target = qr; c.kind = RepOne;
			end else if (nb[1] == "Q" && (nb[2] == "e" || nb[2] == "w"
				|| nb[2] == "s" || nb[2] == "n")) begin
				c.status = (nb[2] == "e") ? StStopE : (nb[2] == "w") ? StStopW :
					(nb[2] == "s") ? StStopS : StStopN;
			end else if (nb[1] == "S" && nb[2] == "r") begin
				c.status = StRaSet; c.target = sr; c.kind = RepOne;
			end else if (nb[1] == "S" && nb[2] == "d") begin
				c.status = StDecSet; c.target = dsel; c.kind = RepOne;
			end else if (nb[1] == "M") begin
				if (nb[2] == "S") begin
					c.status = StDone; c.kind = RepZero;
				end else if (nb[2] == "e") c.status = StMoveE;
				else if (nb[2] == "w") c.status = StMoveW;
				else if (nb[2] == "s") c.status = StMoveS;
				else if (nb[2] == "n") c.status = StMoveN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			hdr_q <= 1'b0;
			idx_q <= '0;
			cmd_valid <= 1'b0;
			for (int i = 0; i < CmdMax; i++) buf_q[i] <= 8'd0;
		end else begin
			cmd_valid <= in_valid && end_of_message;
			if (in_valid) begin
				if (end_of_message) begin
					cnt_q <= '0;
					hdr_q <= 1'b0;
					idx_q <= '0;
					for (int i = 0; i < CmdMax; i++) buf_q[i] <= 8'd0;
				end else begin
					buf_q <= nb;
					if (in_win) begin
						hdr_q <= hdr_n;
						idx_q <= idx_q + IdxW'(1);
						if (hdr_n && cnt_q < 5'(CommandLength)) cnt_q <= cnt_q + 5'd1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && end_of_message) cmd_out <= c;
	end

`ifndef ASSERT_OFF
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 5'(CommandLength)) else $error("capture count overrun");
	a_idx: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= IdxW'(MessageLength)) else $error("byte index overrun");
	a_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != 5'd0) |-> hdr_q) else $error("capture without header");
`endif
endmodule
`default_nettype wire

FILE: design/lx200_back.sv
// Back part: converts positions to ASCII and emits the result beats.
// Depends on lx200_pkg.
`default_nettype none
module lx200_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire lx200_pkg::cmd_t  cmd_in,
	input  wire logic             cmd_valid,
	output logic                  cmd_ready,
	output logic                  empty,
	input  wire logic             pop,
	output logic                  has_reply_byte,
	output logic [7:0]            reply_byte,
	output logic [3:0]            status,
	output logic signed [31:0]    target_value,
	output logic                  last_result
);
	import lx200_pkg::*;

	bk_state_t   st_q, st_n;
	cmd_t        c_q;
	logic [3:0]  k_q;
	logic [20:0] rem_q;      // value being divided, one quotient field a cycle
	logic [7:0]  b_q [10];
	logic [3:0]  n_q;

	// Digit-pair extraction by restoring division over the conversion cycles.
	// Hours stay below 39, but degrees can reach 201 for large declinations.
	logic [7:0]  h_q, m_q, s_q;
	logic        neg_q;
	logic [2:0]  ph_q;

	logic [20:0] div;
	always_comb begin
		case (ph_q)
			3'd0: div = (c_q.kind == RepGr) ? 21'd54000 : 21'd3600;
			3'd1: div = (c_q.kind == RepGr) ? 21'd900 : 21'd60;
			default: div = (c_q.kind == RepGr) ? 21'd15 : 21'd1;
		endcase
	end

	// Tens and ones of a value below 256; v / 10 equals (v * 205) >> 11 there.
	function automatic logic [7:0] a1(input logic [7:0] v);
		logic [15:0] p;
		p = {8'd0, v} * 16'd205;
		return {3'd0, p[15:11]} + 8'd48;
	endfunction
	function automatic logic [7:0] a0(input logic [7:0] v);
		logic [15:0] p;
		logic [7:0]  q;
		p = {8'd0, v} * 16'd205;
		q = {3'd0, p[15:11]};
		return v - {q[6:0], 1'b0} - {q[4:0], 3'b0} + 8'd48;
	endfunction

	always_comb begin
		st_n = st_q;
		case (st_q)
			BkIdle: if (cmd_valid) st_n = BkConv;
			BkConv: if (ph_q == 3'd3) st_n = BkEmit;
			BkEmit: if (pop && k_q + 4'd1 == n_q) st_n = BkIdle;
			default: st_n = BkIdle;
		endcase
	end

	always_comb begin
		cmd_ready = st_q == BkIdle;
		empty = st_q != BkEmit;
		has_reply_byte = c_q.kind != RepNone;
		reply_byte = has_reply_byte ? b_q[k_q] : 8'd0;
		status = c_q.status;
		target_value = c_q.target;
		last_result = k_q + 4'd1 == n_q;
	end

	logic [7:0]  qbit;
	logic [28:0] tr;
	always_comb begin
		tr = {8'd0, rem_q};
		qbit = '0;
		for (int i = 7; i >= 0; i--) begin
			if (tr >= ({8'd0, div} << i)) begin
				tr = tr - ({8'd0, div} << i);
				qbit[i] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BkIdle;
			k_q <= '0;
			ph_q <= '0;
		end else begin
			st_q <= st_n;
			if (st_q == BkIdle) begin
				k_q <= '0;
				ph_q <= '0;
			end else if (st_q == BkConv) begin
				ph_q <= ph_q + 3'd1;
			end else if (pop) begin
				k_q <= k_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == BkIdle && cmd_valid) begin
			c_q <= cmd_in;
			if (cmd_in.kind == RepGd) begin
				neg_q <= cmd_in.dec < 20'd324000;
				rem_q <= (cmd_in.dec >= 20'd324000) ? 21'(cmd_in.dec - 20'd324000)
					: 21'(20'd324000 - cmd_in.dec);
			end else begin
				neg_q <= 1'b0;
				rem_q <= cmd_in.ra;
			end
		end else if (st_q == BkConv && ph_q < 3'd3) begin
			rem_q <= tr[20:0];
			case (ph_q)
				3'd0: h_q <= qbit;
				3'd1: m_q <= qbit;
				default: s_q <= qbit;
			endcase
		end
		if (st_q == BkConv && ph_q == 3'd3) begin
			case (c_q.kind)
				RepGr: begin
					b_q[0] <= a1(h_q); b_q[1] <= a0(h_q); b_q[2] <= ":";
					b_q[3] <= a1(m_q); b_q[4] <= a0(m_q); b_q[5] <= ":";
					b_q[6] <= a1(s_q); b_q[7] <= a0(s_q); b_q[8] <= "#";
					b_q[9] <= 8'd0; n_q <= 4'd9;
				end
				RepGd: begin
					b_q[0] <= neg_q ? "-" : "+";
					b_q[1] <= a1(h_q); b_q[2] <= a0(h_q); b_q[3] <= ":";
					b_q[4] <= a1(m_q); b_q[5] <= a0(m_q); b_q[6] <= ":";
					b_q[7] <= a1(s_q); b_q[8] <= a0(s_q); b_q[9] <= "#";
					n_q <= 4'd10;
				end
				RepOne: begin
					b_q[0] <= "1"; n_q <= 4'd1;
					for (int i = 1; i < 10; i++) b_q[i] <= 8'd0;
				end
				RepZero: begin
					b_q[0] <= "0"; n_q <= 4'd1;
					for (int i = 1; i < 10; i++) b_q[i] <= 8'd0;
				end
				default: begin
					n_q <= 4'd1;
					for (int i = 0; i < 10; i++) b_q[i] <= 8'd0;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_k: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == BkEmit) |-> (k_q < n_q)) else $error("beat index past count");
	a_ret: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == BkEmit && pop && last_result) |=> st_q == BkIdle)
		else $error("did not return to idle");
	a_conv: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == BkConv) |-> (ph_q <= 3'd3)) else $error("conversion overrun");
`endif
endmodule
`default_nettype wire

FILE: design/lx200_cmdq.sv
// Two-entry queue of decoded commands between front and back.
// Depends on lx200_pkg.
`default_nettype none
module lx200_cmdq (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire lx200_pkg::cmd_t  wr_data,
	input  wire logic             wr_en,
	output logic                  full,
	output lx200_pkg::cmd_t       rd_data,
	output logic                  rd_valid,
	input  wire logic             rd_en
);
	import lx200_pkg::*;

	cmd_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (wr_en) wp_q <= ~wp_q;
			if (rd_en && rd_valid) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr_en) - 2'(rd_en && rd_valid);
		end
	end

`ifndef ASSERT_OFF
	a_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && full && !rd_en)) else $error("command queue overflow");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2) else $error("command queue count");
	a_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 || cnt_q == 2'd2) |-> (wp_q == rp_q)) else $error("pointer skew");
`endif
endmodule
`default_nettype wire

FILE: design/lx200_command_parser.sv
// Top level of the LX200 command parser: front, command queue and back.
// Depends on lx200_pkg, lx200_front, lx200_cmdq and lx200_back.
`default_nettype none
// The parser takes one message byte per input beat, pushed while full is low,
// and gives its results as beats from a queue-like output (empty, pop). Each
// byte is captured and classified as it arrives; on the last byte of a message
// the decoded command is registered in the front and then enters a two-entry
// command queue, so further messages keep arriving while replies are sent.
// The back part turns a position into hours or degrees, minutes and seconds
// in four steps: three steps each produce one quotient and the fourth formats
// the ASCII bytes. It then offers one result beat per cycle while pop is high:
// GR gives nine beats, GD ten, set commands one beat carrying '1', MS one
// carrying '0', and every other message one beat without a reply byte. After
// the last beat of a message the back part returns to idle, where it takes the
// next command. The input stalls only when two messages wait that the back part
// has not started, counting one that is still leaving the front.
module lx200_command_parser #(
	parameter int unsigned MESSAGE_LENGTH = 64,
	parameter int unsigned COMMAND_LENGTH = 19
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  wire logic [7:0]        rx_byte,
	input  wire logic              end_of_message,
	input  wire logic [20:0]       ra_position,
	input  wire logic [19:0]       dec_position,
	output logic                   empty,
	input  wire logic              pop,
	output logic                   has_reply_byte,
	output logic [7:0]             reply_byte,
	output logic [3:0]             status,
	output logic signed [31:0]     target_value,
	output logic                   last_result
);
	import lx200_pkg::*;

	cmd_t fc, qc;
	logic fv, qv, qfull, bready, acc;

	// Full also covers a front command and a queued one waiting on a busy back.
	assign full = qfull;
	assign acc = push && !full;

	lx200_front #(.MessageLength(MESSAGE_LENGTH), .CommandLength(COMMAND_LENGTH)) u_front (
		.clk, .arst_n, .in_valid(acc), .rx_byte, .end_of_message,
		.ra_position, .dec_position, .cmd_out(fc), .cmd_valid(fv)
	);

	// The queue is declared full one entry early so the registered front output
	// always finds room.
	logic qf2;
	lx200_cmdq u_q (
		.clk, .arst_n, .wr_data(fc), .wr_en(fv), .full(qf2),
		.rd_data(qc), .rd_valid(qv), .rd_en(bready)
	);
	assign qfull = qf2 || (fv && qv && !bready);

	lx200_back u_back (
		.clk, .arst_n, .cmd_in(qc), .cmd_valid(qv), .cmd_ready(bready),
		.empty, .pop, .has_reply_byte, .reply_byte, .status, .target_value, .last_result
	);

`ifndef ASSERT_OFF
	a_nofull: assert property (@(posedge clk) disable iff (!arst_n)
		fv |-> !qf2 || bready) else $error("front command lost");
	a_emp: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !bready) else $error("output while back idle");
	a_acc: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !acc) else $error("accept while full");
`endif
endmodule
`default_nettype wire
